// ----- sv/plf_pkg.sv -----
// Shared types, widths and constants of the palette linear fade block.
`timescale 1ns / 1ps

package plf_pkg;

    // Default palette size.
    localparam int ENTRIES_DEFAULT = 16;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int INDEX_W = 4;
    localparam int COLOR_W = 15;
    localparam int BANK_W  = 5;
    localparam int TICK_W  = 16;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TICK   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANK_SELECT = 2'd2;

    localparam logic [TICK_W-1:0] FADE_LENGTH_RESET = 16'h0010;
    localparam logic [TICK_W-1:0] STOP_TICK_RESET   = 16'd17;

    // Channel masks of an RGB555 color, each channel kept in place.
    localparam logic [COLOR_W-1:0] RED_MASK   = 15'h001F;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 15'h03E0;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 15'h7C00;

    // Fraction t/T is held with this many bits below the binary point.
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W    = FRAC_BITS + 1;

    // Width of a channel difference times a tick count.
    localparam int PROD_W = COLOR_W + TICK_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_START  = 2'd0,
        OP_LOAD_TARGET = 2'd1,
        OP_RESTART     = 2'd2,
        OP_TICK        = 2'd3
    } op_t;

endpackage

// ----- sv/palette_linear_fade_top.sv -----
// Top level of the palette linear fade: palette memories, tick control and output register.
//
//   Channel  Direction  Payload
//   s_axis   in         tuser: operation; tdata: entry_index, color_value
//   m_axis   out        tuser: finished; tlast: last; tdata: out_bank, out_index, out_color
//   cfg      in         cfg_index selects fade_length, stop_tick or bank_select
//
// A load or restart is taken while idle. A tick that finds the fade over registers a
// finished result in a finish state. A fading tick runs the bit-serial fraction divider,
// then issues one palette entry per cycle, unless the output stalls, into a five-stage
// pipeline; input is taken again once the last color enters the output register. Reset
// is synchronous, clears the tick counter and valid bits and restores the configuration
// defaults; the palettes are not cleared. A stalled output holds the pipeline.
`timescale 1ns / 1ps

module palette_linear_fade_top #(
    parameter int ENTRIES = plf_pkg::ENTRIES_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [plf_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // entry_index, color_value
    input  logic [plf_pkg::OP_W-1:0]          s_axis_tuser,  // operation

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [plf_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // out_bank, out_index, out_color
    output logic                              m_axis_tuser,  // finished
    output logic                              m_axis_tlast,

    input  logic                              cfg_we,
    input  logic [plf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [plf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDE_W = IDX_W + plf_pkg::INDEX_W;
    localparam int CW     = plf_pkg::COLOR_W;
    localparam int IW     = plf_pkg::INDEX_W;
    localparam int BW     = plf_pkg::BANK_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIN,
        ST_DIV,
        ST_RUN
    } state_t;

    state_t state_reg;

    logic [plf_pkg::TICK_W-1:0] tick_count_reg;
    logic [plf_pkg::TICK_W-1:0] tick_count_next;
    logic [plf_pkg::TICK_W-1:0] fade_length_reg;
    logic [plf_pkg::TICK_W-1:0] stop_tick_reg;
    logic [BW-1:0]              bank_select_reg;

    // Palette memories.
    logic [CW-1:0] start_mem   [ENTRIES];
    logic [CW-1:0] target_mem  [ENTRIES];
    logic [CW-1:0] start_rd_reg;
    logic [CW-1:0] target_rd_reg;

    // Entry issue and pipeline bookkeeping.
    logic             issuing_reg;
    logic [IDX_W-1:0] issue_cnt_reg;
    logic             v_rd_reg, v_b_reg, v_c_reg, v_d_reg;
    logic             last_rd_reg, last_b_reg, last_c_reg, last_d_reg;
    logic [IDX_W-1:0] idx_rd_reg, idx_b_reg, idx_c_reg, idx_d_reg;

    // Output register.
    logic             m_valid_reg;
    logic [BW-1:0]    out_bank_reg;
    logic [IW-1:0]    out_index_reg;
    logic [CW-1:0]    out_color_reg;
    logic             out_finished_reg;
    logic             out_last_reg;

    plf_pkg::op_t     in_op;
    logic [IW-1:0]    in_entry_index;
    logic [CW-1:0]    in_color;
    logic             in_acc;
    logic             fade_over;
    logic             div_start;
    logic             div_done;
    logic [plf_pkg::FRAC_W-1:0] frac;
    logic             adv;
    logic [WIDE_W-1:0] ld_wide;
    logic              ld_ok;
    logic [IDX_W-1:0]  ld_addr;
    logic [WIDE_W-1:0] out_idx_wide;
    logic [CW-1:0]     red_res, green_res, blue_res;
    logic [CW-1:0]     mixed_color;

    assign in_op          = plf_pkg::op_t'(s_axis_tuser);
    assign in_entry_index = s_axis_tdata[IW-1:0];
    assign in_color       = s_axis_tdata[IW+CW-1:IW];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign adv           = !m_valid_reg || m_axis_tready;

    assign fade_over = (tick_count_reg == stop_tick_reg) || (tick_count_reg > fade_length_reg);
    assign div_start = in_acc && (in_op == plf_pkg::OP_TICK) && !fade_over;
    assign tick_count_next = tick_count_reg + 1'b1;

    assign ld_wide = WIDE_W'(in_entry_index);
    assign ld_ok   = ld_wide < WIDE_W'(ENTRIES);
    assign ld_addr = ld_wide[IDX_W-1:0];

    assign out_idx_wide = WIDE_W'(idx_d_reg);

    plf_frac_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tick_count_reg),
        .divisor  (fade_length_reg),
        .done     (div_done),
        .quotient (frac)
    );

    plf_lane u_red (
        .aclk       (aclk),
        .adv        (adv),
        .start_val  (start_rd_reg & plf_pkg::RED_MASK),
        .target_val (target_rd_reg & plf_pkg::RED_MASK),
        .tick       (tick_count_reg),
        .span       (fade_length_reg),
        .frac       (frac),
        .result     (red_res)
    );

    plf_lane u_green (
        .aclk       (aclk),
        .adv        (adv),
        .start_val  (start_rd_reg & plf_pkg::GREEN_MASK),
        .target_val (target_rd_reg & plf_pkg::GREEN_MASK),
        .tick       (tick_count_reg),
        .span       (fade_length_reg),
        .frac       (frac),
        .result     (green_res)
    );

    plf_lane u_blue (
        .aclk       (aclk),
        .adv        (adv),
        .start_val  (start_rd_reg & plf_pkg::BLUE_MASK),
        .target_val (target_rd_reg & plf_pkg::BLUE_MASK),
        .tick       (tick_count_reg),
        .span       (fade_length_reg),
        .frac       (frac),
        .result     (blue_res)
    );

    assign mixed_color = (red_res & plf_pkg::RED_MASK)
                       | (green_res & plf_pkg::GREEN_MASK)
                       | (blue_res & plf_pkg::BLUE_MASK);

    // Control: state, counters, registers, valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            tick_count_reg  <= '0;
            fade_length_reg <= plf_pkg::FADE_LENGTH_RESET;
            stop_tick_reg   <= plf_pkg::STOP_TICK_RESET;
            bank_select_reg <= '0;
            issuing_reg     <= 1'b0;
            issue_cnt_reg   <= '0;
            v_rd_reg        <= 1'b0;
            v_b_reg         <= 1'b0;
            v_c_reg         <= 1'b0;
            v_d_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    plf_pkg::REG_FADE_LENGTH: fade_length_reg <= cfg_wdata;
                    plf_pkg::REG_STOP_TICK:   stop_tick_reg   <= cfg_wdata;
                    plf_pkg::REG_BANK_SELECT: bank_select_reg <= cfg_wdata[BW-1:0];
                    default: ;
                endcase
            end

            if (adv) begin
                v_rd_reg    <= issuing_reg;
                v_b_reg     <= v_rd_reg;
                v_c_reg     <= v_b_reg;
                v_d_reg     <= v_c_reg;
                m_valid_reg <= v_d_reg || (state_reg == ST_FIN);
                if (issuing_reg) begin
                    if (issue_cnt_reg == LAST_IDX) begin
                        issuing_reg <= 1'b0;
                    end else begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                end
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (in_op)
                            plf_pkg::OP_RESTART: tick_count_reg <= '0;
                            plf_pkg::OP_TICK:    state_reg <= fade_over ? ST_FIN : ST_DIV;
                            default: ;
                        endcase
                    end
                end
                ST_FIN: begin
                    if (adv) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg     <= ST_RUN;
                        issuing_reg   <= 1'b1;
                        issue_cnt_reg <= '0;
                    end
                end
                ST_RUN: begin
                    // The tick is complete once its last color enters the output register.
                    if (adv && v_d_reg && last_d_reg) begin
                        state_reg      <= ST_IDLE;
                        tick_count_reg <= tick_count_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Palette memories. Loads happen only while idle and reads count only during a tick,
    // so a read that meets a load on the same entry in the same cycle is never used.
    always_ff @(posedge aclk) begin
        if (in_acc && ld_ok) begin
            if (in_op == plf_pkg::OP_LOAD_START) begin
                start_mem[ld_addr] <= in_color;
            end
            if (in_op == plf_pkg::OP_LOAD_TARGET) begin
                target_mem[ld_addr] <= in_color;
            end
        end
        if (adv) begin
            start_rd_reg  <= start_mem[issue_cnt_reg];
            target_rd_reg <= target_mem[issue_cnt_reg];
        end
    end

    // Pipeline payload and output register.
    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_rd_reg  <= issue_cnt_reg;
            last_rd_reg <= (issue_cnt_reg == LAST_IDX);
            idx_b_reg   <= idx_rd_reg;
            last_b_reg  <= last_rd_reg;
            idx_c_reg   <= idx_b_reg;
            last_c_reg  <= last_b_reg;
            idx_d_reg   <= idx_c_reg;
            last_d_reg  <= last_c_reg;

            out_bank_reg <= bank_select_reg;
            if (state_reg == ST_FIN) begin
                out_index_reg    <= '0;
                out_color_reg    <= '0;
                out_finished_reg <= 1'b1;
                out_last_reg     <= 1'b1;
            end else begin
                out_index_reg    <= out_idx_wide[IW-1:0];
                out_color_reg    <= mixed_color;
                out_finished_reg <= 1'b0;
                out_last_reg     <= last_d_reg;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_color_reg, out_index_reg, out_bank_reg};
    assign m_axis_tuser  = out_finished_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- sv/plf_frac_div.sv -----
// Bit-serial divider that forms the fade fraction t * 2^16 / T for one tick.
`timescale 1ns / 1ps

module plf_frac_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [plf_pkg::TICK_W-1:0]        dividend,
    input  logic [plf_pkg::TICK_W-1:0]        divisor,
    output logic                              done,
    output logic [plf_pkg::FRAC_W-1:0]        quotient
);

    localparam int STEPS = plf_pkg::FRAC_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int REM_W = plf_pkg::TICK_W + 1;

    logic [REM_W-1:0]          rem_reg;
    logic [plf_pkg::FRAC_W-1:0] quo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic                      ge;
    logic [REM_W-1:0]          rem_sub;

    // The dividend never exceeds the divisor, so the quotient has one integer bit
    // and the partial remainder stays below the divisor after each step.
    assign ge      = rem_reg >= {1'b0, divisor};
    assign rem_sub = ge ? (rem_reg - {1'b0, divisor}) : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= {1'b0, dividend};
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[plf_pkg::FRAC_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/plf_lane.sv -----
// One color channel: pipelined a + (b - a) * t / T with a fraction estimate and correction.
`timescale 1ns / 1ps

module plf_lane (
    input  logic                               aclk,
    input  logic                               adv,
    input  logic [plf_pkg::COLOR_W-1:0]        start_val,
    input  logic [plf_pkg::COLOR_W-1:0]        target_val,
    input  logic [plf_pkg::TICK_W-1:0]         tick,
    input  logic [plf_pkg::TICK_W-1:0]         span,
    input  logic [plf_pkg::FRAC_W-1:0]         frac,
    output logic [plf_pkg::COLOR_W-1:0]        result
);

    localparam int CW    = plf_pkg::COLOR_W;
    localparam int TW    = plf_pkg::TICK_W;
    localparam int FW    = plf_pkg::FRAC_W;
    localparam int PW    = plf_pkg::PROD_W;
    localparam int FP_W  = CW + FW;
    localparam int FB    = plf_pkg::FRAC_BITS;

    logic          span_zero;

    // Difference stage.
    logic [CW-1:0] mag_b_reg;
    logic          neg_b_reg;
    logic [CW-1:0] base_b_reg;

    // Estimate stage.
    logic [FP_W-1:0] frac_prod;
    logic [PW-1:0]   dt_prod;
    logic [CW-1:0]   qest_c_reg;
    logic [PW-1:0]   dt_c_reg;
    logic            neg_c_reg;
    logic [CW-1:0]   base_c_reg;

    // Back-multiply stage.
    logic [PW-1:0]   qspan_prod;
    logic [PW-1:0]   qspan_d_reg;
    logic [PW-1:0]   dt_d_reg;
    logic [CW-1:0]   qest_d_reg;
    logic            neg_d_reg;
    logic [CW-1:0]   base_d_reg;

    // Correction.
    logic [PW-1:0]   rem;
    logic            bump;
    logic [CW-1:0]   quot;

    assign span_zero = (span == '0);

    assign frac_prod  = {{CW{1'b0}}, frac} * {{FW{1'b0}}, mag_b_reg};
    assign dt_prod    = {{CW{1'b0}}, tick} * {{TW{1'b0}}, mag_b_reg};
    assign qspan_prod = {{CW{1'b0}}, span} * {{TW{1'b0}}, qest_c_reg};

    always_ff @(posedge aclk) begin
        if (adv) begin
            // A zero fade length gives the target, so the base becomes the target.
            if (span_zero) begin
                mag_b_reg  <= '0;
                neg_b_reg  <= 1'b0;
                base_b_reg <= target_val;
            end else begin
                neg_b_reg  <= target_val < start_val;
                mag_b_reg  <= (target_val < start_val) ? (start_val - target_val)
                                                       : (target_val - start_val);
                base_b_reg <= start_val;
            end

            qest_c_reg <= frac_prod[FB+CW-1:FB];
            dt_c_reg   <= dt_prod;
            neg_c_reg  <= neg_b_reg;
            base_c_reg <= base_b_reg;

            qspan_d_reg <= qspan_prod;
            dt_d_reg    <= dt_c_reg;
            qest_d_reg  <= qest_c_reg;
            neg_d_reg   <= neg_c_reg;
            base_d_reg  <= base_c_reg;
        end
    end

    // The truncated fraction makes the estimate at most one below the true quotient.
    assign rem    = dt_d_reg - qspan_d_reg;
    assign bump   = !span_zero && (rem >= {{CW{1'b0}}, span});
    assign quot   = qest_d_reg + {{(CW-1){1'b0}}, bump};
    assign result = neg_d_reg ? (base_d_reg - quot) : (base_d_reg + quot);

endmodule

// ----- sv/plf_checker.sv -----
// Port-level checker for the palette linear fade, bound to the top level.
`timescale 1ns / 1ps

module plf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [plf_pkg::OP_W-1:0]          s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [plf_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input logic                              m_axis_tuser,
    input logic                              m_axis_tlast
);

    localparam int BW = plf_pkg::BANK_W;
    localparam int TW = plf_pkg::M_TDATA_W;

    // A held result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output transaction changed while stalled");

    // A finished result ends its tick and carries neither index nor color.
    a_finished_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[TW-1:BW] == '0))
        else $error("finished transaction malformed");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A tick transaction occupies the block, so the next cycle takes no input.
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == plf_pkg::OP_TICK)
            |=> !s_axis_tready)
        else $error("input accepted right after a tick");

    // A load or restart on an empty output produces no result.
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid
            && (s_axis_tuser != plf_pkg::OP_TICK) |=> !m_axis_tvalid)
        else $error("result appeared without a tick");

endmodule

bind palette_linear_fade_top plf_checker u_plf_checker (.*);

// ----- verif/palette_linear_fade_top_test.sv -----
// Self-checking testbench of the palette linear fade block with a scoreboard class.
`timescale 1ns / 1ps

module palette_linear_fade_top_test;
    import plf_pkg::*;

    localparam int ENTRY_COUNT     = 16;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int PHASE_COUNT     = 8;

    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic               finished;
        logic               last;
    } fade_color_t;

    class fade_scoreboard;
        logic [COLOR_W-1:0] start_pal[ENTRY_COUNT];
        logic [COLOR_W-1:0] target_pal[ENTRY_COUNT];
        logic [TICK_W-1:0]  ticks;
        logic [TICK_W-1:0]  fade_len;
        logic [TICK_W-1:0]  stop_at;
        logic [BANK_W-1:0]  bank;
        fade_color_t        expected_colors[$];
        int                 errors;

        function new();
            ticks    = '0;
            fade_len = FADE_LENGTH_RESET;
            stop_at  = STOP_TICK_RESET;
            bank     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FADE_LENGTH: fade_len = value;
                REG_STOP_TICK:   stop_at = value;
                REG_BANK_SELECT: bank = value[BANK_W-1:0];
                default: ;
            endcase
        endfunction

        // One channel, kept in its own bit position; the quotient truncates toward zero.
        function logic [COLOR_W-1:0] blend_channel(logic [COLOR_W-1:0] a, logic [COLOR_W-1:0] b,
                                                   logic [COLOR_W-1:0] mask);
            longint av;
            longint bv;
            longint mixed;
            av = longint'(a & mask);
            bv = longint'(b & mask);
            if (fade_len == 0)
                return b & mask;
            mixed = av + ((bv - av) * longint'(ticks)) / longint'(fade_len);
            return mixed[COLOR_W-1:0] & mask;
        endfunction

        function void note_input(op_t op, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
            fade_color_t item;
            case (op)
                OP_LOAD_START:  start_pal[idx] = color;
                OP_LOAD_TARGET: target_pal[idx] = color;
                OP_RESTART:     ticks = '0;
                OP_TICK: begin
                    if (ticks == stop_at || ticks > fade_len) begin
                        item = '0;
                        item.bank = bank;
                        item.finished = 1'b1;
                        item.last = 1'b1;
                        expected_colors.push_back(item);
                    end else begin
                        for (int i = 0; i < ENTRY_COUNT; i++) begin
                            item.bank = bank;
                            item.index = i[INDEX_W-1:0];
                            item.color = blend_channel(start_pal[i], target_pal[i], RED_MASK)
                                       | blend_channel(start_pal[i], target_pal[i], GREEN_MASK)
                                       | blend_channel(start_pal[i], target_pal[i], BLUE_MASK);
                            item.finished = 1'b0;
                            item.last = (i == ENTRY_COUNT - 1);
                            expected_colors.push_back(item);
                        end
                        ticks = ticks + 1'b1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(fade_color_t got);
            fade_color_t want;
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result bank %0d index %0d color %h finished %b last %b",
                         $time, got.bank, got.index, got.color, got.finished, got.last);
                errors++;
                return;
            end
            want = expected_colors.pop_front();
            if (got !== want) begin
                $display("%0t: expected bank %0d index %0d color %h finished %b last %b",
                         $time, want.bank, want.index, want.color, want.finished, want.last);
                $display("%0t:   actual bank %0d index %0d color %h finished %b last %b",
                         $time, got.bank, got.index, got.color, got.finished, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fade_scoreboard sb;
    fade_color_t    observed;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    int             hold_off_asks;
    int             quiet_cycles = 0;

    palette_linear_fade_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Both channels are observed at the edge, before any new values are applied.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(op_t'(s_axis_tuser), s_axis_tdata[INDEX_W-1:0],
                              s_axis_tdata[INDEX_W +: COLOR_W]);
            if (m_axis_tvalid && m_axis_tready) begin
                observed.bank     = m_axis_tdata[BANK_W-1:0];
                observed.index    = m_axis_tdata[BANK_W +: INDEX_W];
                observed.color    = m_axis_tdata[BANK_W + INDEX_W +: COLOR_W];
                observed.finished = m_axis_tuser;
                observed.last     = m_axis_tlast;
                sb.check_result(observed);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("palette_linear_fade_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off that lets the block back up.
    initial begin
        int hold_off_seen;
        hold_off_seen = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_asks != hold_off_seen) begin
                hold_off_seen = hold_off_asks;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(op_t op, logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] color);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W - COLOR_W - INDEX_W){1'b0}}, color, idx};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic send_random_load();
        send_item(op_t'($urandom_range(1)), INDEX_W'($urandom_range(15)),
                  COLOR_W'($urandom_range(32767)));
    endtask

    task automatic send_tick();
        send_item(OP_TICK, INDEX_W'($urandom_range(15)), COLOR_W'($urandom_range(32767)));
    endtask

    // Waits until every expected color is out and the block has had time to go quiet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [TICK_W-1:0] fade, logic [TICK_W-1:0] stop,
                              logic [BANK_W-1:0] bank);
        cfg_we <= 1'b1;
        cfg_index <= REG_FADE_LENGTH;
        cfg_wdata <= fade;
        sb.write_reg(REG_FADE_LENGTH, fade);
        @(posedge aclk);
        cfg_index <= REG_STOP_TICK;
        cfg_wdata <= stop;
        sb.write_reg(REG_STOP_TICK, stop);
        @(posedge aclk);
        cfg_index <= REG_BANK_SELECT;
        cfg_wdata <= CFG_DATA_W'(bank);
        sb.write_reg(REG_BANK_SELECT, CFG_DATA_W'(bank));
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 12; recv_stall_pct = 12; end
        endcase
    endtask

    initial begin
        int sent;
        int run_len;
        int cap;

        sb = new();
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_asks  = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the stop tick at zero a fresh counter is already over, so these ticks
        // never touch the palettes before they are loaded.
        set_config(16'd16, 16'd0, 5'd31);
        send_tick();
        send_item(OP_RESTART, 4'd15, 15'h7FFF);
        send_tick();
        drain();

        // Fill both palettes, with full-scale swings on a few entries.
        for (int i = 0; i < ENTRY_COUNT; i++) begin
            case (i)
                0:  begin send_item(OP_LOAD_START, INDEX_W'(i), 15'h7FFF);
                          send_item(OP_LOAD_TARGET, INDEX_W'(i), 15'h0000); end
                5:  begin send_item(OP_LOAD_START, INDEX_W'(i), RED_MASK);
                          send_item(OP_LOAD_TARGET, INDEX_W'(i), BLUE_MASK); end
                9:  begin send_item(OP_LOAD_START, INDEX_W'(i), GREEN_MASK);
                          send_item(OP_LOAD_TARGET, INDEX_W'(i), RED_MASK | BLUE_MASK); end
                15: begin send_item(OP_LOAD_START, INDEX_W'(i), 15'h0000);
                          send_item(OP_LOAD_TARGET, INDEX_W'(i), 15'h7FFF); end
                default: begin
                    send_item(OP_LOAD_START, INDEX_W'(i), COLOR_W'($urandom_range(32767)));
                    send_item(OP_LOAD_TARGET, INDEX_W'(i), COLOR_W'($urandom_range(32767)));
                end
            endcase
        end
        drain();

        // A short fade that runs past its end, then a zero-length fade.
        set_config(16'd4, 16'd5, 5'd9);
        send_item(OP_RESTART, 4'd0, 15'h0000);
        repeat (7) send_tick();
        drain();
        set_config(16'd0, 16'd65535, 5'd0);
        send_item(OP_RESTART, 4'd0, 15'h0000);
        repeat (3) send_tick();
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: set_config(16'd16, 16'd17, 5'd0);
                1: set_config(16'd0, 16'd65535, 5'd31);
                2: set_config(16'd65535, 16'd3, 5'd5);
                3: set_config(16'd3, 16'd4, 5'd17);
                4: set_config(16'd7, 16'd0, 5'd22);
                5: set_config(16'd5, 16'd65535, 5'd10);
                6: set_config(16'd65535, 16'd65535, 5'd31);
                default: set_config(TICK_W'($urandom_range(1, 10)), TICK_W'($urandom_range(12)),
                                    BANK_W'($urandom_range(31)));
            endcase
            set_idling(p % 4);
            if (p == 0)
                hold_off_asks++;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    // A restart followed by ticks, which can reach the end of short fades.
                    send_item(OP_RESTART, INDEX_W'($urandom_range(15)),
                              COLOR_W'($urandom_range(32767)));
                    sent++;
                    cap = (sb.fade_len + 3 < 20) ? sb.fade_len + 3 : 20;
                    run_len = $urandom_range(1, cap);
                    repeat (run_len) begin
                        if ($urandom_range(99) < 20) begin
                            send_random_load();
                            sent++;
                        end
                        send_tick();
                        sent++;
                    end
                end else begin
                    send_item(op_t'($urandom_range(3)), INDEX_W'($urandom_range(15)),
                              COLOR_W'($urandom_range(32767)));
                    sent++;
                end
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("palette_linear_fade_top verification clean");
        else
            $display("palette_linear_fade_top verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/plf_pkg.sv
sv/plf_frac_div.sv
sv/plf_lane.sv
sv/palette_linear_fade_top.sv
sv/plf_checker.sv
verif/palette_linear_fade_top_test.sv
